/* design/b2d_pkg.sv */
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants and types for the binary to decimal digit converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int IN_DATA_W       = 128;  // value_low, value_high
    localparam int HALF_W          = 64;
    localparam int OUT_DATA_W      = 8;    // digit_char padded to a byte
    localparam int CHAR_W          = 6;
    localparam int DEF_VALUE_WIDTH = 128;
    localparam int Q_DEPTH         = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_b2d_result;

endpackage

/* design/b2d_front.sv */
// ----------------------------------------------------------------------------
// b2d_front
// Input side: takes values, masks them to the working width and holds them
// in a two-entry queue for the conversion engine.
// ----------------------------------------------------------------------------
module b2d_front import b2d_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [IN_DATA_W-1:0]   i_in_data,
    output logic                   o_q_valid,
    output logic [VALUE_WIDTH-1:0] o_q_value,
    input  logic                   i_q_pop
);

    localparam int PtrW = $clog2(Q_DEPTH);
    localparam int CntW = $clog2(Q_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PtrW-1:0]        r_wr_ptr;
    logic [PtrW-1:0]        r_rd_ptr;
    logic [CntW-1:0]        r_count;
    logic                   w_push;

    assign o_in_ready = (r_count != CntW'(Q_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_value  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            // bits above the working width are dropped here
            r_mem[r_wr_ptr] <= i_in_data[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/b2d_back.sv */
// ----------------------------------------------------------------------------
// b2d_back
// Conversion engine: bit-serial double dabble over the value, then a scan
// of the BCD digits from the top, dropping leading zeros, into an output
// register.
// ----------------------------------------------------------------------------
module b2d_back import b2d_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [VALUE_WIDTH-1:0] i_q_value,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_b2d_result            o_out
);

    // ceil(W * log10(2)) digits, with margin, covers any W-bit value
    localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BcdW      = NumDigits * 4;
    localparam int CntW      = $clog2(VALUE_WIDTH + 1);
    localparam int DigW      = $clog2(NumDigits);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             r_state,   n_state;
    logic [VALUE_WIDTH-1:0] r_bin,     n_bin;
    logic [BcdW-1:0]        r_bcd,     n_bcd;
    logic [CntW-1:0]        r_cnt,     n_cnt;
    logic [DigW-1:0]        r_dig,     n_dig;
    logic                   r_started, n_started;
    logic                   r_out_valid, n_out_valid;
    t_b2d_result            r_out,     n_out;

    logic [BcdW-1:0] w_adj;
    logic [3:0]      w_cur;
    logic            w_emit;
    logic            w_slot_free;

    always_comb begin
        for (int k = 0; k < NumDigits; k++) begin
            w_adj[k*4 +: 4] = r_bcd[k*4 +: 4]
                            + ((r_bcd[k*4 +: 4] >= 4'd5) ? 4'd3 : 4'd0);
        end
    end

    assign w_cur       = r_bcd[r_dig*4 +: 4];
    assign w_emit      = r_started || (w_cur != 4'd0) || (r_dig == '0);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_dig       = r_dig;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_bin   = i_q_value;
                    n_bcd   = '0;
                    n_cnt   = CntW'(VALUE_WIDTH);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BcdW-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    n_dig     = DigW'(NumDigits - 1);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!w_emit) begin
                    n_dig = r_dig - 1'b1;
                end else if (w_slot_free) begin
                    n_out_valid      = 1'b1;
                    n_out.digit_char = ASCII_ZERO + {2'b00, w_cur};
                    n_out.last_digit = (r_dig == '0);
                    n_started        = 1'b1;
                    if (r_dig == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dig = r_dig - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_dig <= n_dig;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/binary_to_decimal_digits_core.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_core
// Unsigned binary to ASCII decimal converter, most significant digit first,
// no leading zeros, tlast on the final digit.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction carries
//  s_axis   | in        | one value (low half, high half)
//  m_axis   | out       | one digit character, tlast on the final digit
//
//  Each value goes through the engine in order: a load, then the serial double
//  dabble loop over every bit of the value, then the scan over every BCD
//  digit, leading zeros included.
//  The two-entry input queue keeps taking values while the engine works, until it is full.
//  Output stalls hold the digit scan; nothing else is lost or repeated.
//  Reset (synchronous, active low) empties the queue and idles the engine.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_core import b2d_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] value_low, [127:64] value_high
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                  m_axis_tlast    // last_digit
);

    logic                   w_q_valid;
    logic [VALUE_WIDTH-1:0] w_q_value;
    logic                   w_q_pop;
    t_b2d_result            w_out;

    b2d_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .o_q_valid  (w_q_valid),
        .o_q_value  (w_q_value),
        .i_q_pop    (w_q_pop)
    );

    b2d_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_value   (w_q_value),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - CHAR_W){1'b0}}, w_out.digit_char};
    assign m_axis_tlast = w_out.last_digit;

    // set between the first and final digit of a run
    logic r_run_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_run_open <= !m_axis_tlast;
        end
    end

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out.digit_char >= ASCII_ZERO)
                       && (w_out.digit_char <= ASCII_ZERO + 6'd9))
        else $error("digit character out of range");

    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_run_open && (w_out.digit_char == ASCII_ZERO))
            |-> m_axis_tlast)
        else $error("leading zero digit emitted");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("engine took a value from an empty queue");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_to_decimal_digits_core. Values go in on the
// slave stream; each one is also converted to decimal digits in the bench and
// the digits queued. Every digit transaction on the master stream is matched
// against the oldest queued digit, tlast included. Directed edge values come
// first, then random values of every bit length, with random idling on both
// streams, a back-to-back stretch and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import b2d_pkg::*;

    localparam int VALUE_W    = DEF_VALUE_WIDTH;
    localparam int MAX_DIGITS = 39;
    localparam int IDLE_PCT   = 18;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 1200;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [IN_DATA_W-1:0] WIDTH_MASK =
        (VALUE_W >= IN_DATA_W) ? '1 : ((IN_DATA_W'(1) << VALUE_W) - 1);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [63:0] value_low, [127:64] value_high
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [5:0] digit_char, [7:6] zero
    logic                  m_axis_tlast;        // last_digit

    t_b2d_result expected_digits[$];
    int          idle_pct = IDLE_PCT;
    int          hold_left = 0;
    int          error_count = 0;
    int          values_sent = 0;
    int          digits_checked = 0;
    int          stall_cycles = 0;
    bit          length_seen [1:MAX_DIGITS];

    binary_to_decimal_digits_core #(
        .VALUE_WIDTH(VALUE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Decimal expansion of one value, queued most significant digit first
    function automatic void queue_decimal_digits(input logic [IN_DATA_W-1:0] value);
        logic [IN_DATA_W-1:0] rest;
        logic [3:0]           digit [MAX_DIGITS];
        int                   n;
        t_b2d_result          r;
        rest = value & WIDTH_MASK;
        n = 0;
        do begin
            digit[n] = 4'(rest % 10);
            rest = rest / 10;
            n++;
        end while (rest != 0 && n < MAX_DIGITS);
        length_seen[n] = 1'b1;
        for (int k = n - 1; k >= 0; k--) begin
            r.digit_char = ASCII_ZERO + CHAR_W'(digit[k]);
            r.last_digit = (k == 0);
            expected_digits.push_back(r);
        end
    endfunction

    function automatic logic [IN_DATA_W-1:0] power_of_ten(input int exponent);
        logic [IN_DATA_W-1:0] p;
        p = 1;
        for (int i = 0; i < exponent; i++) p = p * 10;
        return p;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_word();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Random value with a random bit length, top bit set so every digit count turns up
    function automatic logic [IN_DATA_W-1:0] random_value();
        logic [IN_DATA_W-1:0] v;
        int                   nbits;
        nbits = $urandom_range(IN_DATA_W, 0);
        if (nbits == 0)
            return '0;
        v = random_word() & ((IN_DATA_W'(1) << nbits) - 1);
        v[nbits-1] = 1'b1;
        return v;
    endfunction

    // Leaves tvalid high after the transaction so the next call can follow back to back
    task automatic send_value(input logic [IN_DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= random_word();
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_decimal_digits(value);
        values_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_edge_values();
        logic [IN_DATA_W-1:0] v [$];
        v = '{'0, 1, 9, 10, 99, 100,
              power_of_ten(19) - 1, power_of_ten(19),
              {64'h0, {64{1'b1}}}, {64'h1, 64'h0}, {{64{1'b1}}, 64'h0},
              power_of_ten(38) - 1, power_of_ten(38),
              {1'b1, 127'h0}, '1,
              {32{4'h5}}, {32{4'hA}}, power_of_ten(9)};
        foreach (v[i]) send_value(v[i]);
    endtask

    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        for (int i = 0; i < count; i++)
            send_value(($urandom_range(3) == 0) ? random_value() : IN_DATA_W'($urandom_range(999)));
        idle_pct = IDLE_PCT;
    endtask

    // Output held off long enough that the input queue fills and tready drops
    task automatic test_output_hold(input int count);
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < count; i++) send_value(random_value());
    endtask

    task automatic test_random_values(input int count);
        for (int i = 0; i < count; i++)
            send_value(($urandom_range(9) == 0) ? random_word() : random_value());
    endtask

    // Digit checker and output-side flow control
    always @(posedge i_clk) begin
        t_b2d_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_digits.size() == 0) begin
                $display("%0t: unexpected digit transaction: char %0d last %0b",
                         $time, m_axis_tdata[CHAR_W-1:0], m_axis_tlast);
                error_count++;
            end else begin
                want = expected_digits.pop_front();
                digits_checked++;
                if (m_axis_tdata[CHAR_W-1:0] !== want.digit_char) begin
                    $display("%0t: digit_char mismatch: expected %0d actual %0d",
                             $time, want.digit_char, m_axis_tdata[CHAR_W-1:0]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last_digit) begin
                    $display("%0t: last_digit mismatch: expected %0b actual %0b",
                             $time, want.last_digit, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tdata[OUT_DATA_W-1:CHAR_W] !== '0) begin
                    $display("%0t: tdata padding mismatch: expected 0 actual %0d",
                             $time, m_axis_tdata[OUT_DATA_W-1:CHAR_W]);
                    error_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d digits outstanding",
                     $time, STALL_LIMIT, expected_digits.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int lengths;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_back_to_back(60);
        test_output_hold(10);
        test_random_values(410);
        stop_sending();

        while (expected_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        lengths = 0;
        foreach (length_seen[i]) lengths += length_seen[i];
        $display("Converted %0d values, checked %0d digit transactions.",
                 values_sent, digits_checked);
        $display("Digit counts covered: %0d of %0d, with one long output hold-off.",
                 lengths, MAX_DIGITS);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/b2d_pkg.sv
design/b2d_front.sv
design/b2d_back.sv
design/binary_to_decimal_digits_core.sv
sim/tb.sv
